// ----- rtl/qfpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfpt_pkg: shared types and constants of the quadratic fit proximity trigger
// Transaction payloads, configuration struct, register indexes, the
// determinant program run by the multiply-accumulate unit, and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package qfpt_pkg;

  // Narrow operand width (power sums, sized for windows of up to 64 entries)
  localparam int NW = 68;
  // Wide operand width (cofactors, determinant, numerator)
  localparam int WW = 160;
  // Divider working width
  localparam int DW = WW + 18;
  // Radix-16 digits per narrow operand
  localparam int NDIG = NW / 4;
  // Wide register file depth
  localparam int NWREG = 11;
  // Quotient bits produced by the divider
  localparam int QW = 17;
  localparam int ADDR_W = 5;

  typedef struct packed {
    logic [7:0]  range_mm;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] predicted_length;
    logic               motor_drive;
    logic               fit_singular;
  } result_t;

  typedef struct packed {
    logic [7:0]  target_distance;
    logic [15:0] lockout_ms;
    logic [15:0] pulse_ms;
    logic [7:0]  rearm_margin;
    logic [7:0]  range_offset;
    logic [7:0]  lead_ms;
  } cfg_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_LOCKOUT  = 3'd1;
  localparam logic [2:0] REG_PULSE    = 3'd2;
  localparam logic [2:0] REG_MARGIN   = 3'd3;
  localparam logic [2:0] REG_OFFSET   = 3'd4;
  localparam logic [2:0] REG_LEAD     = 3'd5;

  // Narrow operand codes
  localparam logic [3:0] N_S0  = 4'd0;
  localparam logic [3:0] N_S1  = 4'd1;
  localparam logic [3:0] N_S2  = 4'd2;
  localparam logic [3:0] N_S3  = 4'd3;
  localparam logic [3:0] N_S4  = 4'd4;
  localparam logic [3:0] N_T0  = 4'd5;
  localparam logic [3:0] N_T1  = 4'd6;
  localparam logic [3:0] N_T2  = 4'd7;
  localparam logic [3:0] N_L   = 4'd8;
  localparam logic [3:0] N_L2  = 4'd9;
  localparam logic [3:0] N_ONE = 4'd10;

  // Wide register indexes
  localparam logic [3:0] W_C00 = 4'd0;
  localparam logic [3:0] W_C01 = 4'd1;
  localparam logic [3:0] W_C02 = 4'd2;
  localparam logic [3:0] W_C11 = 4'd3;
  localparam logic [3:0] W_C12 = 4'd4;
  localparam logic [3:0] W_C22 = 4'd5;
  localparam logic [3:0] W_V0  = 4'd6;
  localparam logic [3:0] W_V1  = 4'd7;
  localparam logic [3:0] W_V2  = 4'd8;
  localparam logic [3:0] W_DD  = 4'd9;
  localparam logic [3:0] W_NUM = 4'd10;

  typedef struct packed {
    logic       a_wide;
    logic [3:0] a_idx;
    logic [3:0] b_sel;
    logic       sub;
    logic       clr;
    logic       wr;
    logic [3:0] dst;
  } mac_op_t;

  localparam logic [4:0] PC_DET_LAST = 5'd14;
  localparam logic [4:0] PC_LAST     = 5'd26;

  typedef struct packed {
    mac_op_t op;
    logic    shift;
    logic    sum_load;
    logic    sum_sq;
    logic    sum_pow;
    logic    sum_acc;
    logic    mac_load;
    logic    mac_step;
    logic    mac_last;
    logic    mac_wr;
    logic    chk;
    logic    div_abs;
    logic    div_load;
    logic    div_chk;
    logic    div_step;
    logic    commit;
  } dp_cmd_t;

  typedef struct packed {
    logic dd_zero;
  } dp_status_t;

  function automatic mac_op_t mk_op(input logic a_wide, input logic [3:0] a_idx,
                                    input logic [3:0] b_sel, input logic sub,
                                    input logic clr, input logic wr,
                                    input logic [3:0] dst);
    mac_op_t o;
    o.a_wide = a_wide;
    o.a_idx  = a_idx;
    o.b_sel  = b_sel;
    o.sub    = sub;
    o.clr    = clr;
    o.wr     = wr;
    o.dst    = dst;
    return o;
  endfunction

  // Cofactors of the symmetric normal matrix, its determinant, the
  // lead-weighted cofactor rows and the Cramer numerator
  function automatic mac_op_t prog_op(input logic [4:0] pc);
    mac_op_t o;
    o = '0;
    unique case (pc)
      5'd0:  o = mk_op(1'b0, N_S2, N_S4, 1'b0, 1'b1, 1'b0, W_C00);
      5'd1:  o = mk_op(1'b0, N_S3, N_S3, 1'b1, 1'b0, 1'b1, W_C00);
      5'd2:  o = mk_op(1'b0, N_S2, N_S3, 1'b0, 1'b1, 1'b0, W_C01);
      5'd3:  o = mk_op(1'b0, N_S1, N_S4, 1'b1, 1'b0, 1'b1, W_C01);
      5'd4:  o = mk_op(1'b0, N_S1, N_S3, 1'b0, 1'b1, 1'b0, W_C02);
      5'd5:  o = mk_op(1'b0, N_S2, N_S2, 1'b1, 1'b0, 1'b1, W_C02);
      5'd6:  o = mk_op(1'b0, N_S0, N_S4, 1'b0, 1'b1, 1'b0, W_C11);
      5'd7:  o = mk_op(1'b0, N_S2, N_S2, 1'b1, 1'b0, 1'b1, W_C11);
      5'd8:  o = mk_op(1'b0, N_S1, N_S2, 1'b0, 1'b1, 1'b0, W_C12);
      5'd9:  o = mk_op(1'b0, N_S0, N_S3, 1'b1, 1'b0, 1'b1, W_C12);
      5'd10: o = mk_op(1'b0, N_S0, N_S2, 1'b0, 1'b1, 1'b0, W_C22);
      5'd11: o = mk_op(1'b0, N_S1, N_S1, 1'b1, 1'b0, 1'b1, W_C22);
      5'd12: o = mk_op(1'b1, W_C00, N_S0, 1'b0, 1'b1, 1'b0, W_DD);
      5'd13: o = mk_op(1'b1, W_C01, N_S1, 1'b0, 1'b0, 1'b0, W_DD);
      5'd14: o = mk_op(1'b1, W_C02, N_S2, 1'b0, 1'b0, 1'b1, W_DD);
      5'd15: o = mk_op(1'b1, W_C00, N_ONE, 1'b0, 1'b1, 1'b0, W_V0);
      5'd16: o = mk_op(1'b1, W_C01, N_L, 1'b0, 1'b0, 1'b0, W_V0);
      5'd17: o = mk_op(1'b1, W_C02, N_L2, 1'b0, 1'b0, 1'b1, W_V0);
      5'd18: o = mk_op(1'b1, W_C01, N_ONE, 1'b0, 1'b1, 1'b0, W_V1);
      5'd19: o = mk_op(1'b1, W_C11, N_L, 1'b0, 1'b0, 1'b0, W_V1);
      5'd20: o = mk_op(1'b1, W_C12, N_L2, 1'b0, 1'b0, 1'b1, W_V1);
      5'd21: o = mk_op(1'b1, W_C02, N_ONE, 1'b0, 1'b1, 1'b0, W_V2);
      5'd22: o = mk_op(1'b1, W_C12, N_L, 1'b0, 1'b0, 1'b0, W_V2);
      5'd23: o = mk_op(1'b1, W_C22, N_L2, 1'b0, 1'b0, 1'b1, W_V2);
      5'd24: o = mk_op(1'b1, W_V0, N_T0, 1'b0, 1'b1, 1'b0, W_NUM);
      5'd25: o = mk_op(1'b1, W_V1, N_T1, 1'b0, 1'b0, 1'b0, W_NUM);
      5'd26: o = mk_op(1'b1, W_V2, N_T2, 1'b0, 1'b0, 1'b1, W_NUM);
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/qfpt_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfpt_regs: configuration register block
// APB-style write and read of the six trigger settings, reset to defaults.
// ----------------------------------------------------------------------------
module qfpt_regs
  import qfpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_distance <= 8'd50;
      cfg.lockout_ms      <= 16'd800;
      cfg.pulse_ms        <= 16'd100;
      cfg.rearm_margin    <= 8'd9;
      cfg.range_offset    <= 8'd142;
      cfg.lead_ms         <= 8'd10;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET:  cfg.target_distance <= pwdata[7:0];
        REG_LOCKOUT: cfg.lockout_ms      <= pwdata[15:0];
        REG_PULSE:   cfg.pulse_ms        <= pwdata[15:0];
        REG_MARGIN:  cfg.rearm_margin    <= pwdata[7:0];
        REG_OFFSET:  cfg.range_offset    <= pwdata[7:0];
        REG_LEAD:    cfg.lead_ms         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_TARGET:  prdata = 32'(cfg.target_distance);
      REG_LOCKOUT: prdata = 32'(cfg.lockout_ms);
      REG_PULSE:   prdata = 32'(cfg.pulse_ms);
      REG_MARGIN:  prdata = 32'(cfg.rearm_margin);
      REG_OFFSET:  prdata = 32'(cfg.range_offset);
      REG_LEAD:    prdata = 32'(cfg.lead_ms);
      default:     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/qfpt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfpt_ctrl: sequencing state machine
// Walks the window, runs the determinant program on the shared
// multiply-accumulate unit, drives the divider and owns the handshakes.
// ----------------------------------------------------------------------------
module qfpt_ctrl
  import qfpt_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  dp_status_t           status,
  output dp_cmd_t              cmd,
  output logic [$clog2(WINDOW)-1:0] idx
);

  localparam int IW = $clog2(WINDOW);
  localparam logic [IW-1:0] IDX_LAST = IW'(WINDOW - 1);
  localparam logic [4:0]    DIG_LAST = 5'(NDIG - 1);
  localparam logic [4:0]    QDIG_LAST = 5'(QW - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM_LOAD = 4'd1;
  localparam logic [3:0] S_SUM_SQ   = 4'd2;
  localparam logic [3:0] S_SUM_POW  = 4'd3;
  localparam logic [3:0] S_SUM_ACC  = 4'd4;
  localparam logic [3:0] S_MAC_LOAD = 4'd5;
  localparam logic [3:0] S_MAC_STEP = 4'd6;
  localparam logic [3:0] S_MAC_WR   = 4'd7;
  localparam logic [3:0] S_CHK      = 4'd8;
  localparam logic [3:0] S_DIV_ABS  = 4'd9;
  localparam logic [3:0] S_DIV_LOAD = 4'd10;
  localparam logic [3:0] S_DIV_CHK  = 4'd11;
  localparam logic [3:0] S_DIV_STEP = 4'd12;
  localparam logic [3:0] S_COMMIT   = 4'd13;

  logic [3:0]    state, state_next;
  logic [IW-1:0] idx_next;
  logic [4:0]    pc, pc_next;
  logic [4:0]    dig, dig_next;
  logic          result_valid_next;

  assign sample_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      pc           <= '0;
      dig          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      pc           <= pc_next;
      dig          <= dig_next;
      result_valid <= result_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next        = state;
    idx_next          = idx;
    pc_next           = pc;
    dig_next          = dig;
    result_valid_next = result_valid & ~result_ready;
    cmd               = '0;
    cmd.op            = prog_op(pc);
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.shift  = 1'b1;
          idx_next   = '0;
          state_next = S_SUM_LOAD;
        end
      end
      S_SUM_LOAD: begin
        cmd.sum_load = 1'b1;
        state_next   = S_SUM_SQ;
      end
      S_SUM_SQ: begin
        cmd.sum_sq = 1'b1;
        state_next = S_SUM_POW;
      end
      S_SUM_POW: begin
        cmd.sum_pow = 1'b1;
        state_next  = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (idx == IDX_LAST) begin
          pc_next    = '0;
          state_next = S_MAC_LOAD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SUM_LOAD;
        end
      end
      S_MAC_LOAD: begin
        cmd.mac_load = 1'b1;
        dig_next     = '0;
        state_next   = S_MAC_STEP;
      end
      S_MAC_STEP: begin
        cmd.mac_step = 1'b1;
        cmd.mac_last = (dig == DIG_LAST);
        if (dig == DIG_LAST) begin
          state_next = S_MAC_WR;
        end else begin
          dig_next = dig + 1'b1;
        end
      end
      S_MAC_WR: begin
        cmd.mac_wr = 1'b1;
        if (pc == PC_DET_LAST) begin
          state_next = S_CHK;
        end else if (pc == PC_LAST) begin
          state_next = S_DIV_ABS;
        end else begin
          pc_next    = pc + 1'b1;
          state_next = S_MAC_LOAD;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (status.dd_zero) begin
          state_next = S_COMMIT;
        end else begin
          pc_next    = pc + 1'b1;
          state_next = S_MAC_LOAD;
        end
      end
      S_DIV_ABS: begin
        cmd.div_abs = 1'b1;
        state_next  = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV_CHK;
      end
      S_DIV_CHK: begin
        cmd.div_chk = 1'b1;
        dig_next    = '0;
        state_next  = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (dig == QDIG_LAST) begin
          state_next = S_COMMIT;
        end else begin
          dig_next = dig + 1'b1;
        end
      end
      S_COMMIT: begin
        // Hold until the output register is free
        if (!result_valid || result_ready) begin
          cmd.commit        = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/qfpt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfpt_dp: fit datapath
// Sample window, power-sum accumulators, radix-16 multiply-accumulate unit
// with its wide register file, restoring divider and trigger state.
// ----------------------------------------------------------------------------
module qfpt_dp
  import qfpt_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  sample_t              sample,
  input  dp_cmd_t              cmd,
  input  logic [$clog2(WINDOW)-1:0] idx,
  output dp_status_t           status,
  output result_t              result
);

  // Sample window
  logic [31:0]       wt [WINDOW];
  logic signed [8:0] wl [WINDOW];
  logic [31:0]       now;
  logic signed [8:0] len_new;
  logic signed [8:0] len_in;

  // Power sums
  logic signed [15:0] d;
  logic signed [8:0]  len;
  logic signed [31:0] d2;
  logic signed [24:0] dl;
  logic signed [47:0] d3;
  logic signed [63:0] d4;
  logic signed [40:0] d2l;
  logic signed [NW-1:0] s1, s2, s3, s4, t0, t1, t2;
  logic signed [31:0] diff;
  logic signed [15:0] dsat;
  logic [15:0]        lsq;

  // Multiply-accumulate
  logic signed [WW-1:0] wreg [NWREG];
  logic signed [WW-1:0] acc;
  logic signed [WW-1:0] a_sh;
  logic [NW-1:0]        b_sh;
  logic signed [4:0]    dig5;
  logic signed [WW-1:0] prod;

  // Divider
  logic signed [WW-1:0] num;
  logic signed [WW-1:0] dd;
  logic [WW-1:0]        an, ad;
  logic                 neg, sat, singular;
  logic [DW-1:0]        rem, dsh;
  logic                 ge;
  logic [QW-1:0]        q;

  // Trigger
  logic [31:0]        last_fire;
  logic               armed, motor;
  logic signed [15:0] pred;
  logic               big;
  logic [31:0]        elapsed, elapsed2, lf_new;
  logic               fire, motor_new, armed_new;
  logic [8:0]         upper;

  assign now     = wt[WINDOW-1];
  assign len_new = wl[WINDOW-1];
  assign len_in  = $signed({1'b0, cfg.range_offset}) - $signed({1'b0, sample.range_mm});
  assign num     = wreg[W_NUM];
  assign dd      = wreg[W_DD];
  assign status.dd_zero = (dd == '0);
  assign lsq     = 16'(cfg.lead_ms) * 16'(cfg.lead_ms);

  // Shift the window on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        wt[i] <= '0;
        wl[i] <= '0;
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        wt[i] <= wt[i+1];
        wl[i] <= wl[i+1];
      end
      wt[WINDOW-1] <= sample.time_ms;
      wl[WINDOW-1] <= len_in;
    end
  end

  // Time offset from the newest sample, saturated
  always_comb begin
    diff = $signed(wt[idx] - now);
    if (diff > 32'sd32767) begin
      dsat = 16'sd32767;
    end else if (diff < -32'sd32767) begin
      dsat = -16'sd32767;
    end else begin
      dsat = diff[15:0];
    end
  end

  // Per-entry powers and sums
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
      t0 <= '0;
      t1 <= '0;
      t2 <= '0;
    end
    if (cmd.sum_load) begin
      d   <= dsat;
      len <= wl[idx];
    end
    if (cmd.sum_sq) begin
      d2 <= 32'(d) * 32'(d);
      dl <= 25'(d) * 25'(len);
    end
    if (cmd.sum_pow) begin
      d3  <= 48'(d2) * 48'(d);
      d4  <= 64'(d2) * 64'(d2);
      d2l <= 41'(d2) * 41'(len);
    end
    if (cmd.sum_acc) begin
      s1 <= s1 + NW'(d);
      s2 <= s2 + NW'(d2);
      s3 <= s3 + NW'(d3);
      s4 <= s4 + NW'(d4);
      t0 <= t0 + NW'(len);
      t1 <= t1 + NW'(dl);
      t2 <= t2 + NW'(d2l);
    end
  end

  // Narrow operand select
  function automatic logic signed [NW-1:0] pick(input logic [3:0] code);
    logic signed [NW-1:0] v;
    unique case (code)
      N_S0:    v = NW'(WINDOW);
      N_S1:    v = s1;
      N_S2:    v = s2;
      N_S3:    v = s3;
      N_S4:    v = s4;
      N_T0:    v = t0;
      N_T1:    v = t1;
      N_T2:    v = t2;
      N_L:     v = NW'(cfg.lead_ms);
      N_L2:    v = NW'(lsq);
      N_ONE:   v = NW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // One radix-16 digit of the multiplier; the top digit carries the sign
  assign dig5 = {cmd.mac_last & b_sh[3], b_sh[3:0]};
  assign prod = a_sh * WW'(dig5);

  always_ff @(posedge clk) begin
    if (cmd.mac_load) begin
      a_sh <= cmd.op.a_wide ? wreg[cmd.op.a_idx] : WW'(pick(cmd.op.a_idx));
      b_sh <= pick(cmd.op.b_sel);
      if (cmd.op.clr) begin
        acc <= '0;
      end
    end
    if (cmd.mac_step) begin
      acc  <= cmd.op.sub ? acc - prod : acc + prod;
      a_sh <= a_sh <<< 4;
      b_sh <= b_sh >> 4;
    end
    if (cmd.mac_wr && cmd.op.wr) begin
      wreg[cmd.op.dst] <= acc;
    end
  end

  // Rounded quotient (2|16 num| + |dd|) / (2|dd|), one bit per step
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (cmd.div_abs) begin
      an  <= (num[WW-1] ? WW'(-num) : WW'(num)) << 4;
      ad  <= dd[WW-1] ? WW'(-dd) : WW'(dd);
      neg <= num[WW-1] ^ dd[WW-1];
    end
    if (cmd.div_load) begin
      rem <= DW'({an, 1'b0}) + DW'(ad);
      dsh <= DW'(ad) << QW;
    end
    if (cmd.div_chk) begin
      sat <= (rem >= (dsh << 1));
      q   <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[QW-2:0], ge};
      dsh <= dsh >> 1;
    end
    if (cmd.chk) begin
      singular <= status.dd_zero;
    end
  end

  // Prediction, saturated to 16 bits
  assign big = sat | q[QW-1] | q[QW-2];
  always_comb begin
    priority if (singular) begin
      pred = {{3{len_new[8]}}, len_new, 4'b0000};
    end else if (neg) begin
      pred = big ? -16'sd32768 : -$signed(q[15:0]);
    end else begin
      pred = big ? 16'sd32767 : $signed(q[15:0]);
    end
  end

  // Fire, pulse end and re-arm
  assign upper    = 9'(cfg.target_distance) + 9'(cfg.rearm_margin);
  assign elapsed  = now - last_fire;
  assign fire     = (pred < $signed({4'b0000, cfg.target_distance, 4'b0000}))
                    && (elapsed > 32'(cfg.lockout_ms)) && armed;
  assign lf_new   = fire ? now : last_fire;
  assign elapsed2 = now - lf_new;
  assign motor_new = (fire | motor) & ~(elapsed2 > 32'(cfg.pulse_ms));
  assign armed_new = (armed & ~fire)
                     | (pred > $signed({3'b000, upper, 4'b0000}));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_fire <= '0;
      armed     <= 1'b1;
      motor     <= 1'b0;
    end else if (cmd.commit) begin
      last_fire <= lf_new;
      armed     <= armed_new;
      motor     <= motor_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.predicted_length <= pred;
      result.motor_drive      <= motor_new;
      result.fit_singular     <= singular;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/quadratic_fit_proximity_trigger.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_fit_proximity_trigger: least-squares gap prediction and motor pulse
// Sample channel (sample_valid/sample_ready, sample) takes one range reading
// and timestamp per transaction; result channel (result_valid/result_ready,
// result) returns one predicted length, motor level and singular flag each.
// The block works on one sample at a time. After acceptance it walks the
// window entry by entry (load, square, powers, accumulate), then runs 27
// multiply-accumulate operations, each digit by digit on one radix-16
// multiplier, then a restoring divider; when the normal matrix is singular
// it stops after the determinant and skips the divider. Most of the run
// time goes to the shared multiplier. The next sample can be accepted in
// the same cycle that the result becomes valid. sample_ready is high only
// while the block is idle. The result sits in an output register; if the
// receiver stalls, the next fit completes and waits for that register to
// drain. Reset clears the window to zero, arms the trigger, drives the motor
// low and loads the configuration defaults. Configuration is to be written
// through the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module quadratic_fit_proximity_trigger
  import qfpt_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [$clog2(WINDOW)-1:0] idx;

  qfpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qfpt_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd),
    .idx          (idx)
  );

  qfpt_dp #(.WINDOW(WINDOW)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .cmd    (cmd),
    .idx    (idx),
    .status (status),
    .result (result)
  );

endmodule
`default_nettype wire

// ----- rtl/qfpt_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfpt_chk: port-level checker
// Watches the top level's channels and binds to every instance of it.
// ----------------------------------------------------------------------------
module qfpt_chk
  import qfpt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input result_t           result,
  input logic              pready
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // One transaction in flight: ready drops after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted while busy");

  // Nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // Singular fallback is a whole-millimeter length
  a_singular_whole: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.fit_singular |-> result.predicted_length[3:0] == 4'd0)
    else $error("singular result not whole millimeters");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind quadratic_fit_proximity_trigger qfpt_chk u_qfpt_chk (.*);
`default_nettype wire
